// ===== rtl/hvd_pkg.sv =====
`default_nettype none

package hvd_pkg;

   // Lane order of the four angles that go through sine and cosine.
   localparam int LANES      = 4;
   localparam int LANE_DLAT  = 0;
   localparam int LANE_DLON  = 1;
   localparam int LANE_LAT_A = 2;
   localparam int LANE_LAT_B = 3;

   // Widths of the datapath.
   localparam int ANG_W    = 33;
   localparam int XW       = 34;
   localparam int ZW       = 34;
   localparam int SCW      = 32;
   localparam int ROOT_W   = 31;
   localparam int RAD_W    = 62;
   localparam int REM_W    = 34;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 30;

   // Fixed-point constants in Q30 unless noted.
   localparam logic signed [XW-1:0]  CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic signed [ZW-1:0]  HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [XW-1:0]  Q30_ONE         = 34'sd1073741824;
   localparam logic signed [27:0]    DEG2RAD_Q32     = 28'sd74961321;
   localparam logic [RADIUS_W-1:0]   RADIUS_RESET    = 23'd6378137;

   // Arctangent of 2^-k in radians Q30, truncated except for k from 27 to 30.
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
      logic signed [ZW-1:0] v;
      unique case (k)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         5'd31: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hvd_angle.sv =====
`default_nettype none

module hvd_angle #(
   parameter int ANGLE_FRAC_BITS = 22
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic signed [hvd_pkg::ANG_W-1:0]    in_ang [hvd_pkg::LANES],
   output logic                                     out_valid,
   output logic signed [hvd_pkg::ZW-1:0]            out_z [hvd_pkg::LANES],
   output logic                                     out_flip [hvd_pkg::LANES]
);

   localparam int LANES = hvd_pkg::LANES;
   localparam longint unsigned FULL  = 64'd360 << (ANGLE_FRAC_BITS + 1);
   localparam longint unsigned NWRAP = (64'd2147483648 + FULL - 64'd1) / FULL;
   localparam longint unsigned OFFS  = FULL * NWRAP;
   localparam int UW   = 34;
   localparam int LOWW = ANGLE_FRAC_BITS + 4;
   localparam int HW   = UW - LOWW;
   localparam int RW   = LOWW + 6;
   localparam int SW   = RW + 1;
   localparam int PW   = SW + 28;
   localparam logic signed [SW-1:0] FULL_S = SW'(FULL);
   localparam logic signed [SW-1:0] HALF_S = SW'(FULL / 2);
   localparam logic signed [SW-1:0] QTR_S  = SW'(FULL / 4);

   // Full turn is 45 * 2^LOWW, so only the high part needs a remainder by 45.
   function automatic logic [5:0] mod45(input logic [HW-1:0] h);
      logic [HW+5:0] rem;
      rem = (HW + 6)'(h);
      for (int k = HW - 1; k >= 0; k--) begin
         if (rem >= ((HW + 6)'(45) << k)) begin
            rem = rem - ((HW + 6)'(45) << k);
         end
      end
      return rem[5:0];
   endfunction

   logic [3:0]              vld_ff;
   logic [UW-1:0]           u_ff    [LANES];
   logic [RW-1:0]           r_ff    [LANES];
   logic signed [SW-1:0]    a_in    [LANES];
   logic                    flip_in [LANES];
   logic signed [SW-1:0]    a_ff    [LANES];
   logic                    f3_ff   [LANES];
   logic signed [PW-1:0]    prod_ff [LANES];
   logic                    f4_ff   [LANES];

   // Valid bits follow the data through the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // Fold the angle into one quarter turn either side of zero.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         a_in[l]    = signed'({1'b0, r_ff[l]});
         flip_in[l] = 1'b0;
         if (a_in[l] >= HALF_S) begin
            a_in[l] = a_in[l] - FULL_S;
         end
         if (a_in[l] > QTR_S) begin
            a_in[l]    = HALF_S - a_in[l];
            flip_in[l] = 1'b1;
         end else if (a_in[l] < -QTR_S) begin
            a_in[l]    = -HALF_S - a_in[l];
            flip_in[l] = 1'b1;
         end
      end
   end

   // Offset to a positive value, reduce modulo a full turn, fold, scale to radians.
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         u_ff[l]    <= UW'(UW'(in_ang[l]) + UW'(OFFS));
         r_ff[l]    <= {mod45(u_ff[l][UW-1:LOWW]), u_ff[l][LOWW-1:0]};
         a_ff[l]    <= a_in[l];
         f3_ff[l]   <= flip_in[l];
         prod_ff[l] <= PW'(a_ff[l]) * PW'(hvd_pkg::DEG2RAD_Q32);
         f4_ff[l]   <= f3_ff[l];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_z[l]    = hvd_pkg::ZW'(prod_ff[l] >>> (ANGLE_FRAC_BITS + 3));
         out_flip[l] = f4_ff[l];
      end
   end

   assign out_valid = vld_ff[3];

endmodule

`default_nettype wire

// ===== rtl/hvd_cordic_rot.sv =====
`default_nettype none

module hvd_cordic_rot #(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic signed [hvd_pkg::ZW-1:0]     in_z [hvd_pkg::LANES],
   input  wire logic                              in_flip [hvd_pkg::LANES],
   output logic                                   out_valid,
   output logic signed [hvd_pkg::SCW-1:0]         out_sin [hvd_pkg::LANES],
   output logic signed [hvd_pkg::SCW-1:0]         out_cos [hvd_pkg::LANES]
);

   localparam int LANES = hvd_pkg::LANES;
   localparam int XW    = hvd_pkg::XW;
   localparam int ZW    = hvd_pkg::ZW;

   logic [CORDIC_STAGES-1:0]  vld_ff;
   logic signed [XW-1:0]      x_ff [CORDIC_STAGES][LANES];
   logic signed [XW-1:0]      y_ff [CORDIC_STAGES][LANES];
   logic signed [ZW-1:0]      z_ff [CORDIC_STAGES][LANES];
   logic                      f_ff [CORDIC_STAGES][LANES];
   logic signed [XW-1:0]      x_last [LANES];

   // One rotation per stage, all four lanes side by side.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic                  vp;
      logic signed [XW-1:0]  xp [LANES];
      logic signed [XW-1:0]  yp [LANES];
      logic signed [ZW-1:0]  zp [LANES];
      logic                  fp [LANES];

      if (i == 0) begin : g_head
         assign vp = in_valid;
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               xp[l] = hvd_pkg::CORDIC_GAIN_INV;
               yp[l] = '0;
               zp[l] = in_z[l];
               fp[l] = in_flip[l];
            end
         end
      end else begin : g_body
         assign vp = vld_ff[i-1];
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               xp[l] = x_ff[i-1][l];
               yp[l] = y_ff[i-1][l];
               zp[l] = z_ff[i-1][l];
               fp[l] = f_ff[i-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < LANES; l++) begin
            f_ff[i][l] <= fp[l];
            if (!zp[l][ZW-1]) begin
               x_ff[i][l] <= xp[l] - (yp[l] >>> i);
               y_ff[i][l] <= yp[l] + (xp[l] >>> i);
               z_ff[i][l] <= zp[l] - hvd_pkg::atan_q30(5'(i));
            end else begin
               x_ff[i][l] <= xp[l] + (yp[l] >>> i);
               y_ff[i][l] <= yp[l] - (xp[l] >>> i);
               z_ff[i][l] <= zp[l] + hvd_pkg::atan_q30(5'(i));
            end
         end
      end
   end

   // Restore the cosine sign of the folded quadrant and clamp to one.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         x_last[l] = f_ff[CORDIC_STAGES-1][l] ? -x_ff[CORDIC_STAGES-1][l]
                                              : x_ff[CORDIC_STAGES-1][l];
         if (y_ff[CORDIC_STAGES-1][l] > hvd_pkg::Q30_ONE) begin
            out_sin[l] = hvd_pkg::SCW'(hvd_pkg::Q30_ONE);
         end else if (y_ff[CORDIC_STAGES-1][l] < -hvd_pkg::Q30_ONE) begin
            out_sin[l] = hvd_pkg::SCW'(-hvd_pkg::Q30_ONE);
         end else begin
            out_sin[l] = hvd_pkg::SCW'(y_ff[CORDIC_STAGES-1][l]);
         end
         if (x_last[l] > hvd_pkg::Q30_ONE) begin
            out_cos[l] = hvd_pkg::SCW'(hvd_pkg::Q30_ONE);
         end else if (x_last[l] < -hvd_pkg::Q30_ONE) begin
            out_cos[l] = hvd_pkg::SCW'(-hvd_pkg::Q30_ONE);
         end else begin
            out_cos[l] = hvd_pkg::SCW'(x_last[l]);
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/hvd_isqrt.sv =====
`default_nettype none

module hvd_isqrt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic [hvd_pkg::ROOT_W-1:0]       in_val [2],
   output logic                                  out_valid,
   output logic [hvd_pkg::ROOT_W-1:0]            out_root [2]
);

   localparam int STEPS = hvd_pkg::ROOT_W;
   localparam int RAD_W = hvd_pkg::RAD_W;
   localparam int REM_W = hvd_pkg::REM_W;

   logic [STEPS-1:0]   vld_ff;
   logic [REM_W-1:0]   rem_ff  [STEPS][2];
   logic [STEPS-1:0]   root_ff [STEPS][2];
   logic [RAD_W-1:0]   v_ff    [STEPS][2];

   // One result bit per stage: two radicand bits enter the partial remainder.
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic               vp;
      logic [REM_W-1:0]   remp   [2];
      logic [STEPS-1:0]   rootp  [2];
      logic [RAD_W-1:0]   vpv    [2];
      logic [REM_W-1:0]   rem_sh [2];
      logic [REM_W-1:0]   trial  [2];

      if (j == 0) begin : g_head
         assign vp = in_valid;
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               remp[l]  = '0;
               rootp[l] = '0;
               vpv[l]   = {1'b0, in_val[l], 30'b0};
            end
         end
      end else begin : g_body
         assign vp = vld_ff[j-1];
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               remp[l]  = rem_ff[j-1][l];
               rootp[l] = root_ff[j-1][l];
               vpv[l]   = v_ff[j-1][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {remp[l][REM_W-3:0], vpv[l][RAD_W-1:RAD_W-2]};
            trial[l]  = {1'b0, rootp[l], 2'b01};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < 2; l++) begin
            v_ff[j][l] <= vpv[l] << 2;
            if (rem_sh[l] >= trial[l]) begin
               rem_ff[j][l]  <= rem_sh[l] - trial[l];
               root_ff[j][l] <= {rootp[l][STEPS-2:0], 1'b1};
            end else begin
               rem_ff[j][l]  <= rem_sh[l];
               root_ff[j][l] <= {rootp[l][STEPS-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_root[l] = root_ff[STEPS-1][l];
      end
   end

   assign out_valid = vld_ff[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/hvd_cordic_vec.sv =====
`default_nettype none

module hvd_cordic_vec #(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [hvd_pkg::ROOT_W-1:0]    in_y,
   input  wire logic [hvd_pkg::ROOT_W-1:0]    in_x,
   output logic                               out_valid,
   output logic [hvd_pkg::ROOT_W-1:0]         out_angle
);

   localparam int XW = hvd_pkg::XW;
   localparam int ZW = hvd_pkg::ZW;

   logic [CORDIC_STAGES-1:0]  vld_ff;
   logic signed [XW-1:0]      x_ff [CORDIC_STAGES];
   logic signed [XW-1:0]      y_ff [CORDIC_STAGES];
   logic signed [ZW-1:0]      z_ff [CORDIC_STAGES];
   logic signed [ZW-1:0]      z_last;

   // One vectoring step per stage drives y toward zero.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic                  vp;
      logic signed [XW-1:0]  xp;
      logic signed [XW-1:0]  yp;
      logic signed [ZW-1:0]  zp;

      if (i == 0) begin : g_head
         assign vp = in_valid;
         assign xp = signed'(XW'(in_x));
         assign yp = signed'(XW'(in_y));
         assign zp = '0;
      end else begin : g_body
         assign vp = vld_ff[i-1];
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (!yp[XW-1]) begin
            x_ff[i] <= xp + (yp >>> i);
            y_ff[i] <= yp - (xp >>> i);
            z_ff[i] <= zp + hvd_pkg::atan_q30(5'(i));
         end else begin
            x_ff[i] <= xp - (yp >>> i);
            y_ff[i] <= yp + (xp >>> i);
            z_ff[i] <= zp - hvd_pkg::atan_q30(5'(i));
         end
      end
   end

   // Clamp the half angle to the first quadrant.
   always_comb begin
      z_last = z_ff[CORDIC_STAGES-1];
      if (z_last[ZW-1]) begin
         out_angle = '0;
      end else if (z_last > hvd_pkg::HALF_PI_Q30) begin
         out_angle = hvd_pkg::ROOT_W'(hvd_pkg::HALF_PI_Q30);
      end else begin
         out_angle = hvd_pkg::ROOT_W'(z_last);
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/haversine_distance.sv =====
`default_nettype none

// Channel        Handshake               Payload
// request        start / busy            req_lat_a, req_lon_a, req_lat_b, req_lon_b
// response       rsp_valid (strobe)      rsp_distance_sixteenths
// register       psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// A transaction can be started in every cycle; busy stays low.
// The pipeline stages in order: angle reduction, sine/cosine CORDIC, products,
// square roots, arctangent CORDIC, distance scaling.
// Synchronous reset clears the valid bits and sets the radius to 6378137.
// The receiver cannot stall, so the pipeline advances every cycle.

module haversine_distance #(
   parameter int ANGLE_FRAC_BITS = 22,
   parameter int CORDIC_STAGES   = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [29:0]  req_lat_a,
   input  wire logic signed [30:0]  req_lon_a,
   input  wire logic signed [29:0]  req_lat_b,
   input  wire logic signed [30:0]  req_lon_b,
   output logic                     rsp_valid,
   output logic [29:0]              rsp_distance_sixteenths,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int LANES  = hvd_pkg::LANES;
   localparam int ANG_W  = hvd_pkg::ANG_W;
   localparam int ZW     = hvd_pkg::ZW;
   localparam int SCW    = hvd_pkg::SCW;
   localparam int ROOT_W = hvd_pkg::ROOT_W;
   localparam int RW     = hvd_pkg::RADIUS_W;

   logic [RW-1:0]              radius_ff;
   logic [RW-1:0]              radius_in;
   logic                       accept;
   logic signed [ANG_W-1:0]    ang [LANES];
   logic                       ang_valid;
   logic signed [ZW-1:0]       ang_z [LANES];
   logic                       ang_flip [LANES];
   logic                       sc_valid;
   logic signed [SCW-1:0]      sc_sin [LANES];
   logic signed [SCW-1:0]      sc_cos [LANES];
   logic signed [63:0]         cc_full, t_full, p_full, q_full;
   logic signed [SCW-1:0]      cc_ff, t_ff, p_ff, q_ff, p2_ff;
   logic [2:0]                 mv_ff;
   logic signed [SCW:0]        a_sum;
   logic [ROOT_W-1:0]          a_in;
   logic [ROOT_W-1:0]          rad_ff [2];
   logic                       rt_valid;
   logic [ROOT_W-1:0]          roots [2];
   logic                       vec_valid;
   logic [ROOT_W-1:0]          half;
   logic [53:0]                prod_ff;
   logic                       pv_ff;
   logic [54:0]                dist_sum;

   // Register port: the radius register at addresses zero to three.
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(radius_ff);

   always_comb begin
      radius_in = radius_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         radius_in = pwdata[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hvd_pkg::RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // Angles in half-units: differences of the points, and doubled latitudes.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      ang[hvd_pkg::LANE_DLAT]  = ANG_W'(req_lat_b) - ANG_W'(req_lat_a);
      ang[hvd_pkg::LANE_DLON]  = ANG_W'(req_lon_b) - ANG_W'(req_lon_a);
      ang[hvd_pkg::LANE_LAT_A] = ANG_W'(req_lat_a) <<< 1;
      ang[hvd_pkg::LANE_LAT_B] = ANG_W'(req_lat_b) <<< 1;
   end

   hvd_angle #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ang    (ang),
      .out_valid (ang_valid),
      .out_z     (ang_z),
      .out_flip  (ang_flip)
   );

   hvd_cordic_rot #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_z      (ang_z),
      .in_flip   (ang_flip),
      .out_valid (sc_valid),
      .out_sin   (sc_sin),
      .out_cos   (sc_cos)
   );

   // Haversine term: a = sin^2(dlat/2) + cos(lat_a)cos(lat_b)sin^2(dlon/2).
   always_comb begin
      cc_full = 64'(sc_cos[hvd_pkg::LANE_LAT_A]) * 64'(sc_cos[hvd_pkg::LANE_LAT_B]);
      t_full  = 64'(sc_sin[hvd_pkg::LANE_DLON]) * 64'(sc_sin[hvd_pkg::LANE_DLON]);
      p_full  = 64'(sc_sin[hvd_pkg::LANE_DLAT]) * 64'(sc_sin[hvd_pkg::LANE_DLAT]);
      q_full  = 64'(cc_ff) * 64'(t_ff);
      a_sum   = (SCW + 1)'(p2_ff) + (SCW + 1)'(q_ff);
      if (a_sum[SCW]) begin
         a_in = '0;
      end else if (a_sum > (SCW + 1)'(hvd_pkg::Q30_ONE)) begin
         a_in = ROOT_W'(hvd_pkg::Q30_ONE);
      end else begin
         a_in = ROOT_W'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      cc_ff     <= SCW'(cc_full >>> 30);
      t_ff      <= SCW'(t_full >>> 30);
      p_ff      <= SCW'(p_full >>> 30);
      q_ff      <= SCW'(q_full >>> 30);
      p2_ff     <= p_ff;
      rad_ff[0] <= a_in;
      rad_ff[1] <= ROOT_W'(hvd_pkg::Q30_ONE) - a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= '0;
      end else begin
         mv_ff <= {mv_ff[1:0], sc_valid};
      end
   end

   hvd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mv_ff[2]),
      .in_val    (rad_ff),
      .out_valid (rt_valid),
      .out_root  (roots)
   );

   hvd_cordic_vec #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_y      (roots[0]),
      .in_x      (roots[1]),
      .out_valid (vec_valid),
      .out_angle (half)
   );

   // Scale the half angle by the radius and round; the 30-bit result cannot
   // exceed its range since the half angle is clamped to pi/2.
   assign dist_sum = 55'(prod_ff) + 55'(1 << 24);

   always_ff @(posedge clock) begin
      prod_ff                 <= 54'(half) * 54'(radius_ff);
      rsp_distance_sixteenths <= dist_sum[54:25];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         pv_ff     <= vec_valid;
         rsp_valid <= pv_ff;
      end
   end

endmodule

`default_nettype wire
